// ===== rtl/iau_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// iau_pkg
// Shared types and constants of the integer activation unit.
// ----------------------------------------------------------------------------
package iau_pkg;

    localparam int VALUE_WIDTH_DEF = 32;
    localparam int QuoW            = 9;
    localparam int CountW          = 16;
    localparam int RemW            = CountW + QuoW;
    localparam int OutW            = 32;
    localparam int CodeW           = 7;
    localparam int CfgIdxW         = 2;
    localparam int CfgDataW        = 16;

    typedef enum logic [2:0] {
        KIND_SIGMOID = 3'd0,
        KIND_TANH    = 3'd1,
        KIND_RESCALE = 3'd2,
        KIND_RELU8   = 3'd3,
        KIND_LEAKY   = 3'd4,
        KIND_PASS    = 3'd5
    } t_kind;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_KIND  = 2'd0,
        CFG_SHIFT = 2'd1,
        CFG_COUNT = 2'd2
    } t_cfg_idx;

    localparam logic [CodeW-1:0] CODE_SAT  = 7'd127;
    localparam logic [CodeW-1:0] CODE_ONE  = 7'd1;
    localparam logic [CodeW-1:0] CODE_LEAK = 7'd5;

    localparam logic signed [11:0] JOINT [6] = '{
        -12'sd127, -12'sd74, -12'sd31, 12'sd32, 12'sd75, 12'sd128
    };
    localparam logic [CodeW-1:0] SEG_CODE [7] = '{
        CODE_SAT, 7'd8, 7'd2, 7'd1, 7'd2, 7'd8, CODE_SAT
    };

    // reciprocal of 5 scaled by 2^18, exact for magnitudes below 2^18
    localparam logic [16:0] RECIP5   = 17'd52429;
    localparam int          RecipSh  = 18;

    typedef struct packed {
        logic [RemW-1:0]   rem;
        logic [QuoW-1:0]   quo;
        logic [CountW-1:0] divisor;
        logic              neg;
        logic              big;
        logic              curve;
        logic              tanh;
        logic [OutW-1:0]   direct;
        logic [CodeW-1:0]  code;
    } t_div_item;

endpackage
`default_nettype wire

// ===== rtl/iau_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// iau_in_if
// Input stream channel: one pre-activation value per beat.
// ----------------------------------------------------------------------------
interface iau_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] pre_value;
    modport source (output valid, output pre_value, input ready);
    modport sink   (input valid, input pre_value, output ready);
endinterface
`default_nettype wire

// ===== rtl/iau_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// iau_out_if
// Result stream channel: activated value and inverse gradient per beat.
// ----------------------------------------------------------------------------
interface iau_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] act_value;
    logic [6:0]  grad_inverse;
    modport source (output valid, output act_value, output grad_inverse, input ready);
    modport sink   (input valid, input act_value, input grad_inverse, output ready);
endinterface
`default_nettype wire

// ===== rtl/iau_cfg_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// iau_cfg_if
// Configuration write channel: register index and write data per beat.
// ----------------------------------------------------------------------------
interface iau_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [15:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/iau_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// iau_front
// Two pipeline stages: power-of-two scaling and leak multiply, then the
// direct modes, magnitude and divisor setup for the curve modes.
// ----------------------------------------------------------------------------
module iau_front #(
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_en,
    input  wire logic                     i_valid,
    input  wire logic [31:0]              i_pre_value,
    input  wire logic [2:0]               i_kind,
    input  wire logic [3:0]               i_shift,
    input  wire logic [15:0]              i_count,
    output logic                          o_valid,
    output iau_pkg::t_div_item            o_item
);
    import iau_pkg::*;

    localparam int W  = VALUE_WIDTH;
    localparam int BW = ((W > RemW) ? W : RemW) + 1;

    logic                  r_v1;
    logic signed [W-1:0]   r_v;
    logic signed [W-1:0]   r_x1;
    logic [31:0]           r_prod;
    logic                  r_v2;
    t_div_item             r_item;

    logic signed [W-1:0]   vin;
    logic [W-1:0]          bias;
    logic signed [W:0]     sum;
    logic signed [W:0]     shifted;
    logic [15:0]           mag16;
    logic [31:0]           n_prod;

    logic signed [31:0]    v32;
    logic signed [31:0]    x32;
    logic [W-1:0]          amag;
    logic [CountW-1:0]     divisor;
    logic                  curve;
    logic                  is_tanh;
    logic [OutW-1:0]       direct;
    logic [CodeW-1:0]      code;
    t_div_item             n_item;

    always_comb begin
        vin     = signed'(i_pre_value[W-1:0]);
        bias    = ~({W{1'b1}} << i_shift) & {W{vin[W-1]}};
        sum     = (W+1)'(vin) + signed'({1'b0, bias});
        shifted = sum >>> i_shift;
        mag16   = 16'(32'sd0 - 32'(vin));
        n_prod  = 32'(mag16) * 32'(RECIP5);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_v    <= vin;
            r_x1   <= shifted[W-1:0];
            r_prod <= n_prod;
        end
    end

    always_comb begin
        v32     = 32'(r_v);
        x32     = 32'(r_x1);
        amag    = r_x1[W-1] ? W'(-r_x1) : W'(r_x1);
        curve   = 1'b0;
        is_tanh = 1'b0;
        direct  = v32;
        code    = CODE_ONE;
        case (i_kind)
            KIND_SIGMOID: begin
                curve = 1'b1;
            end
            KIND_TANH: begin
                curve   = 1'b1;
                is_tanh = 1'b1;
            end
            KIND_RESCALE: begin
                direct = x32;
            end
            KIND_RELU8: begin
                if (v32 < 0) begin
                    direct = '0;
                    code   = CODE_SAT;
                end else if (v32 > 32'sd127) begin
                    direct = 32'd127;
                    code   = CODE_SAT;
                end
            end
            KIND_LEAKY: begin
                if (v32 < -32'sd32768) begin
                    direct = 32'hFFFF_8000;
                    code   = CODE_SAT;
                end else if (v32 < 0) begin
                    direct = 32'd0 - {{RecipSh{1'b0}}, r_prod[31:RecipSh]};
                    code   = CODE_LEAK;
                end else if (v32 >= 32'sd32767) begin
                    direct = 32'd32767;
                    code   = CODE_SAT;
                end
            end
            default: begin
                direct = v32;
            end
        endcase
        divisor = (is_tanh && (i_count != '0)) ? i_count : CountW'(1);
        n_item.rem     = RemW'(amag);
        n_item.quo     = '0;
        n_item.divisor = divisor;
        n_item.neg     = r_x1[W-1];
        n_item.big     = BW'(amag) >= BW'({divisor, {QuoW{1'b0}}});
        n_item.curve   = curve;
        n_item.tanh    = is_tanh;
        n_item.direct  = direct;
        n_item.code    = code;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_v2;
    assign o_item  = r_item;

endmodule
`default_nettype wire

// ===== rtl/iau_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// iau_div
// Pipelined restoring divider, one quotient bit per stage, for the
// magnitude of the scaled input over the tanh item count (one in the other modes).
// ----------------------------------------------------------------------------
module iau_div (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_en,
    input  wire logic               i_valid,
    input  iau_pkg::t_div_item      i_item,
    output logic                    o_valid,
    output iau_pkg::t_div_item      o_item
);
    import iau_pkg::*;

    logic      r_vld [QuoW];
    t_div_item r_st  [QuoW];

    for (genvar j = 0; j < QuoW; j++) begin : g_stage
        localparam int Bit = QuoW - 1 - j;
        t_div_item       cur;
        t_div_item       n_st;
        logic            cur_v;
        logic [RemW-1:0] trial;

        always_comb begin
            if (j == 0) begin
                cur   = i_item;
                cur_v = i_valid;
            end else begin
                cur   = r_st[(j == 0) ? 0 : j-1];
                cur_v = r_vld[(j == 0) ? 0 : j-1];
            end
            trial = RemW'(cur.divisor) << Bit;
            n_st  = cur;
            if (cur.rem >= trial) begin
                n_st.rem      = cur.rem - trial;
                n_st.quo[Bit] = 1'b1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[j] <= 1'b0;
            end else if (i_en) begin
                r_vld[j] <= cur_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_st[j] <= n_st;
            end
        end
    end

    assign o_valid = r_vld[QuoW-1];
    assign o_item  = r_st[QuoW-1];

endmodule
`default_nettype wire

// ===== rtl/iau_curve.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// iau_curve
// Segment lookup and piecewise-linear sigmoid and tanh, result select
// and the output register.
// ----------------------------------------------------------------------------
module iau_curve (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_en,
    input  wire logic               i_valid,
    input  iau_pkg::t_div_item      i_item,
    output logic                    o_valid,
    output logic [31:0]             o_act_value,
    output logic [6:0]              o_grad_inverse
);
    import iau_pkg::*;

    function automatic logic signed [11:0] tdiv(input logic signed [11:0] x, input int sh);
        logic signed [11:0] b;
        b = x[11] ? 12'((1 << sh) - 1) : 12'sd0;
        return (x + b) >>> sh;
    endfunction

    logic                  r_valid;
    logic [OutW-1:0]       r_value;
    logic [CodeW-1:0]      r_code;

    logic signed [11:0]    qs;
    logic signed [11:0]    x;
    logic [2:0]            seg;
    logic signed [11:0]    y;
    logic [OutW-1:0]       n_value;
    logic [CodeW-1:0]      n_code;

    always_comb begin
        qs = signed'({3'b000, i_item.quo});
        if (i_item.big) begin
            x = i_item.neg ? -12'sd1000 : 12'sd1000;
        end else begin
            x = i_item.neg ? -qs : qs;
        end
        seg = '0;
        for (int k = 0; k < 6; k++) begin
            seg = seg + 3'(x >= JOINT[k]);
        end
        if (i_item.tanh) begin
            case (seg)
                3'd0:    y = -12'sd128;
                3'd1:    y = tdiv(x, 2) - 12'sd88;
                3'd2:    y = x - 12'sd32;
                3'd3:    y = x <<< 1;
                3'd4:    y = x + 12'sd32;
                3'd5:    y = tdiv(x, 2) + 12'sd88;
                default: y = 12'sd127;
            endcase
            if (y < -12'sd128) begin
                y = -12'sd128;
            end else if (y > 12'sd127) begin
                y = 12'sd127;
            end
        end else begin
            case (seg)
                3'd0:    y = 12'sd1;
                3'd1:    y = tdiv(x, 3) + 12'sd20;
                3'd2:    y = tdiv(x, 1) + 12'sd48;
                3'd3:    y = x + 12'sd64;
                3'd4:    y = tdiv(x, 1) + 12'sd80;
                3'd5:    y = tdiv(x, 3) + 12'sd108;
                default: y = 12'sd127;
            endcase
            if (y < 12'sd1) begin
                y = 12'sd1;
            end else if (y > 12'sd127) begin
                y = 12'sd127;
            end
        end
        if (i_item.curve) begin
            n_value = OutW'(y);
            n_code  = SEG_CODE[seg];
        end else begin
            n_value = i_item.direct;
            n_code  = i_item.code;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_value <= n_value;
            r_code  <= n_code;
        end
    end

    assign o_valid        = r_valid;
    assign o_act_value    = r_value;
    assign o_grad_inverse = r_code;

endmodule
`default_nettype wire

// ===== rtl/integer_activation_unit_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// integer_activation_unit_top
// Piecewise-linear integer activation: sigmoid, tanh, rescale, 8-bit relu,
// leaky relu and pass-through on a stream of signed values.
//
// Usage: write activation_kind (index 0), scale_shift (1) and item_count (2)
// on i_cfg while the stream is empty; the cfg channel is always ready. Push
// pre-activation beats on i_in; each gives exactly one beat on o_out, in order.
// Each accepted input beat passes two front stages, the nine stages of
// the bit-per-stage divider for the tanh item count and the output
// register. Throughput is one beat per cycle while o_out takes its
// beats. The whole pipeline advances together: when o_out holds a beat
// that is not taken, every stage holds and i_in.ready drops in the same
// cycle, so nothing is lost or repeated. Reset clears all valid bits and
// sets the registers to sigmoid, shift 0 and item count 1.
// ----------------------------------------------------------------------------
module integer_activation_unit_top #(
    parameter int VALUE_WIDTH = iau_pkg::VALUE_WIDTH_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    iau_in_if.sink     i_in,
    iau_out_if.source  o_out,
    iau_cfg_if.sink    i_cfg
);
    import iau_pkg::*;

    logic [2:0]        r_kind;
    logic [3:0]        r_shift;
    logic [CountW-1:0] r_count;

    logic              en;
    logic              front_valid;
    t_div_item         front_item;
    logic              div_valid;
    t_div_item         div_item;
    logic              out_valid;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind  <= KIND_SIGMOID;
            r_shift <= '0;
            r_count <= CountW'(1);
        end else if (i_cfg.valid) begin
            unique case (t_cfg_idx'(i_cfg.index))
                CFG_KIND:  r_kind  <= i_cfg.data[2:0];
                CFG_SHIFT: r_shift <= i_cfg.data[3:0];
                CFG_COUNT: r_count <= i_cfg.data;
                default: begin
                end
            endcase
        end
    end

    assign en         = !out_valid || o_out.ready;
    assign i_in.ready = en;
    assign o_out.valid = out_valid;

    iau_front #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (en),
        .i_valid     (i_in.valid),
        .i_pre_value (i_in.pre_value),
        .i_kind      (r_kind),
        .i_shift     (r_shift),
        .i_count     (r_count),
        .o_valid     (front_valid),
        .o_item      (front_item)
    );

    iau_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (front_valid),
        .i_item  (front_item),
        .o_valid (div_valid),
        .o_item  (div_item)
    );

    iau_curve u_curve (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_en           (en),
        .i_valid        (div_valid),
        .i_item         (div_item),
        .o_valid        (out_valid),
        .o_act_value    (o_out.act_value),
        .o_grad_inverse (o_out.grad_inverse)
    );

    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_valid && !o_out.ready) |-> !i_in.ready)
        else $error("input taken while output stalled");

    a_grad_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid |-> (o_out.grad_inverse != '0))
        else $error("zero inverse gradient");

    a_sigmoid_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_valid && (r_kind == KIND_SIGMOID)) |->
        ((o_out.act_value >= 32'd1) && (o_out.act_value <= 32'd127)))
        else $error("sigmoid result out of range");

endmodule
`default_nettype wire
